FILE: rtl/bsf_pkg.sv
// Shared constants for the byte stream FIFO.
// Depth, derived index and count widths, field widths and command codes.
// No dependencies.
package bsf_pkg;

  localparam int DEPTH = 4096;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int FLD_W = 13;
  localparam int CMP_W = (CNT_W > FLD_W) ? CNT_W : FLD_W;
  localparam int TOT_W = 48;
  localparam int BYTE_W = 8;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic [FLD_W-1:0] CAP_RESET = 13'd4096;

endpackage

FILE: rtl/bsf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read data appears in the cycle after the read enable. No dependencies.
module bsf_ram #(
  parameter int WORDS  = 4096,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/byte_stream_fifo.sv
// Byte stream FIFO top level: command decode, ring pointers, totals, status.
// An input transfer starts a registered head read from the ring RAM, and the result
// registers load from it once the output is free; input stalls during the head read.
// A waiting result holds the next item in its read cycle until taken.
// Synchronous active-low reset clears pointers, totals, closed flag and
// sets the capacity limit to 4096; ring contents are not cleared.
// Depends on bsf_pkg and bsf_ram.
module byte_stream_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bsf_pkg::FLD_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [bsf_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [bsf_pkg::FLD_W-1:0]   in_pop_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bsf_pkg::BYTE_W-1:0]  out_head_byte,
  output logic                        out_head_valid,
  output logic [bsf_pkg::FLD_W-1:0]   out_buffered_count,
  output logic [bsf_pkg::FLD_W-1:0]   out_free_space,
  output logic [bsf_pkg::TOT_W-1:0]   out_total_pushed,
  output logic [bsf_pkg::TOT_W-1:0]   out_total_popped,
  output logic                        out_closed_flag,
  output logic                        out_finished_flag,
  output logic                        out_byte_accepted
);
  import bsf_pkg::*;

  typedef enum logic {S_IDLE, S_RD} state_t;

  state_t             state_r, state_nxt;
  logic [FLD_W-1:0]   cap_r;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [TOT_W-1:0]   pushed_r, pushed_nxt;
  logic [TOT_W-1:0]   popped_r, popped_nxt;
  logic               closed_r, closed_nxt;
  logic               acc_byte_r;
  logic               fwd_r;
  logic [BYTE_W-1:0]  fwd_byte_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  head_r;
  logic               head_valid_r;
  logic [FLD_W-1:0]   buffered_r;
  logic [FLD_W-1:0]   free_r;
  logic [TOT_W-1:0]   tot_push_r;
  logic [TOT_W-1:0]   tot_pop_r;
  logic               closed_out_r;
  logic               finished_r;
  logic               accepted_out_r;

  logic               in_xfer;
  logic               is_push, is_pop, is_close;
  logic               push_ok;
  logic [CMP_W-1:0]   held_ext, cap_ext, cfg_ext, want_ext, take_ext;
  logic [CNT_W-1:0]   take;
  logic [SUM_W-1:0]   rd_sum, rd_wrap;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               out_load;
  logic [BYTE_W-1:0]  head_sel;
  logic [CMP_W-1:0]   free_ext;

  assign in_stall = (state_r == S_RD);
  assign in_xfer  = in_valid && !in_stall;
  assign is_push  = (in_mode == MODE_PUSH);
  assign is_pop   = (in_mode == MODE_POP);
  assign is_close = (in_mode == MODE_CLOSE);

  assign held_ext = CMP_W'(held_r);
  assign cfg_ext  = CMP_W'(cap_r);
  assign cap_ext  = (cfg_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cfg_ext;
  assign want_ext = CMP_W'(in_pop_length);
  assign take_ext = (want_ext < held_ext) ? want_ext : held_ext;
  assign take     = take_ext[CNT_W-1:0];
  assign push_ok  = is_push && !closed_r && (held_ext < cap_ext);

  // take never exceeds held, so the sum stays below twice the depth
  assign rd_sum  = SUM_W'(rd_idx_r) + SUM_W'(take);
  assign rd_wrap = (rd_sum >= SUM_W'(DEPTH)) ? (rd_sum - SUM_W'(DEPTH)) : rd_sum;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    held_nxt   = held_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    closed_nxt = closed_r;
    if (push_ok) begin
      wr_idx_nxt = (wr_idx_r == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
      held_nxt   = held_r + 1'b1;
      pushed_nxt = pushed_r + 1'b1;
    end
    if (is_pop) begin
      rd_idx_nxt = rd_wrap[IDX_W-1:0];
      held_nxt   = held_r - take;
      popped_nxt = popped_r + TOT_W'(take);
    end
    if (is_close) begin
      closed_nxt = 1'b1;
    end
  end

  bsf_ram #(
    .WORDS  (DEPTH),
    .DATA_W (BYTE_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (in_xfer && push_ok),
    .waddr (wr_idx_r),
    .wdata (in_data_byte),
    .re    (in_xfer),
    .raddr (rd_idx_nxt),
    .rdata (ram_rdata)
  );

  // result stage: read data from the RAM, the byte just written into an empty ring, or zero when empty
  assign out_load  = (state_r == S_RD) && (!out_valid_r || !out_stall);
  assign head_sel  = (held_r == '0) ? '0 : (fwd_r ? fwd_byte_r : ram_rdata);
  assign free_ext  = (cap_ext > held_ext) ? (cap_ext - held_ext) : '0;
  assign state_nxt = in_xfer ? S_RD : (out_load ? S_IDLE : state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      held_r      <= '0;
      pushed_r    <= '0;
      popped_r    <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (in_xfer) begin
        wr_idx_r <= wr_idx_nxt;
        rd_idx_r <= rd_idx_nxt;
        held_r   <= held_nxt;
        pushed_r <= pushed_nxt;
        popped_r <= popped_nxt;
        closed_r <= closed_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_byte_r <= push_ok;
      fwd_r      <= push_ok && (held_r == '0);
      fwd_byte_r <= in_data_byte;
    end
    if (out_load) begin
      head_r         <= head_sel;
      head_valid_r   <= (held_r != '0);
      buffered_r     <= held_ext[FLD_W-1:0];
      free_r         <= free_ext[FLD_W-1:0];
      tot_push_r     <= pushed_r;
      tot_pop_r      <= popped_r;
      closed_out_r   <= closed_r;
      finished_r     <= closed_r && (held_r == '0);
      accepted_out_r <= acc_byte_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_head_byte      = head_r;
  assign out_head_valid     = head_valid_r;
  assign out_buffered_count = buffered_r;
  assign out_free_space     = free_r;
  assign out_total_pushed   = tot_push_r;
  assign out_total_popped   = tot_pop_r;
  assign out_closed_flag    = closed_out_r;
  assign out_finished_flag  = finished_r;
  assign out_byte_accepted  = accepted_out_r;

  a_held_matches_totals: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == CNT_W'(pushed_r - popped_r))
    else $error("held count disagrees with transfer totals");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(held_r) <= CMP_W'(DEPTH))
    else $error("held count exceeds ring depth");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed flag cleared without reset");

  a_xfer_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_RD))
    else $error("input transfer did not enter head read");

endmodule

FILE: bench/bsf_status_checker.sv
// Status checker for the byte stream FIFO bench.
// Tracks FIFO state from observed command transfers and compares every status result.
// Depends on bsf_pkg.
module bsf_status_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bsf_pkg::FLD_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [bsf_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [bsf_pkg::FLD_W-1:0]   in_pop_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bsf_pkg::BYTE_W-1:0]  out_head_byte,
  input  logic                        out_head_valid,
  input  logic [bsf_pkg::FLD_W-1:0]   out_buffered_count,
  input  logic [bsf_pkg::FLD_W-1:0]   out_free_space,
  input  logic [bsf_pkg::TOT_W-1:0]   out_total_pushed,
  input  logic [bsf_pkg::TOT_W-1:0]   out_total_popped,
  input  logic                        out_closed_flag,
  input  logic                        out_finished_flag,
  input  logic                        out_byte_accepted,
  output int unsigned                 fail_count,
  output int unsigned                 expected_left
);
  import bsf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] head_byte;
    logic              head_valid;
    logic [FLD_W-1:0]  buffered;
    logic [FLD_W-1:0]  free;
    logic [TOT_W-1:0]  pushed;
    logic [TOT_W-1:0]  popped;
    logic              closed;
    logic              finished;
    logic              accepted;
  } fifo_status_t;

  logic [BYTE_W-1:0] ring_copy [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [TOT_W-1:0]  pushed_cnt;
  logic [TOT_W-1:0]  popped_cnt;
  logic              closed_seen;
  logic [FLD_W-1:0]  cap_limit;
  fifo_status_t      pending_status [$];
  int unsigned       mismatches = 0;

  function automatic fifo_status_t apply_command(input logic [1:0] mode,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [FLD_W-1:0] len);
    fifo_status_t s;
    int cap;
    int held;
    int take;
    int room;
    logic [TOT_W-1:0] diff;
    s = '0;
    cap = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
    diff = pushed_cnt - popped_cnt;
    held = int'(diff[FLD_W-1:0]);
    case (mode)
      MODE_PUSH: begin
        if (!closed_seen && held < cap) begin
          ring_copy[wr_ptr] = data;
          wr_ptr = wr_ptr + 1'b1;
          pushed_cnt = pushed_cnt + 1'b1;
          held = held + 1;
          s.accepted = 1'b1;
        end
      end
      MODE_POP: begin
        take = (int'(len) < held) ? int'(len) : held;
        rd_ptr = rd_ptr + take[IDX_W-1:0];
        popped_cnt = popped_cnt + TOT_W'(take);
        held = held - take;
      end
      MODE_CLOSE: begin
        closed_seen = 1'b1;
      end
      default: begin
      end
    endcase
    room = (cap > held) ? cap - held : 0;
    s.head_valid = (held > 0);
    s.head_byte = (held > 0) ? ring_copy[rd_ptr] : '0;
    s.buffered = held[FLD_W-1:0];
    s.free = room[FLD_W-1:0];
    s.pushed = pushed_cnt;
    s.popped = popped_cnt;
    s.closed = closed_seen;
    s.finished = closed_seen && (held == 0);
    return s;
  endfunction

  function automatic void check_field(input string label, input logic [TOT_W-1:0] want,
                                      input logic [TOT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    fifo_status_t want;
    fifo_status_t got;
    if (!rst_n) begin
      wr_ptr = '0;
      rd_ptr = '0;
      pushed_cnt = '0;
      popped_cnt = '0;
      closed_seen = 1'b0;
      cap_limit = CAP_RESET;
      pending_status.delete();
    end else begin
      if (cfg_we) begin
        cap_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        pending_status.push_back(apply_command(in_mode, in_data_byte, in_pop_length));
      end
      if (out_valid && !out_stall) begin
        got.head_byte = out_head_byte;
        got.head_valid = out_head_valid;
        got.buffered = out_buffered_count;
        got.free = out_free_space;
        got.pushed = out_total_pushed;
        got.popped = out_total_popped;
        got.closed = out_closed_flag;
        got.finished = out_finished_flag;
        got.accepted = out_byte_accepted;
        if (pending_status.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          check_field("head_byte", TOT_W'(want.head_byte), TOT_W'(got.head_byte));
          check_field("head_valid", TOT_W'(want.head_valid), TOT_W'(got.head_valid));
          check_field("buffered_count", TOT_W'(want.buffered), TOT_W'(got.buffered));
          check_field("free_space", TOT_W'(want.free), TOT_W'(got.free));
          check_field("total_pushed", want.pushed, got.pushed);
          check_field("total_popped", want.popped, got.popped);
          check_field("closed_flag", TOT_W'(want.closed), TOT_W'(got.closed));
          check_field("finished_flag", TOT_W'(want.finished), TOT_W'(got.finished));
          check_field("byte_accepted", TOT_W'(want.accepted), TOT_W'(got.accepted));
        end
      end
    end
    expected_left <= pending_status.size();
    fail_count <= mismatches;
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the byte stream FIFO: clock, reset, command stimulus and verdict.
// Sweeps capacity settings with random gaps and stalls; bsf_status_checker scores results.
// Depends on bsf_pkg, byte_stream_fifo and bsf_status_checker.
module tb;
  import bsf_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [FLD_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic [BYTE_W-1:0] in_data_byte;
  logic [FLD_W-1:0]  in_pop_length;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_head_byte;
  logic              out_head_valid;
  logic [FLD_W-1:0]  out_buffered_count;
  logic [FLD_W-1:0]  out_free_space;
  logic [TOT_W-1:0]  out_total_pushed;
  logic [TOT_W-1:0]  out_total_popped;
  logic              out_closed_flag;
  logic              out_finished_flag;
  logic              out_byte_accepted;

  int unsigned fail_count;
  int unsigned expected_left;
  int unsigned idle_cycles = 0;
  int          burst_left = 0;
  bit          hold_trigger = 1'b0;

  byte_stream_fifo dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .in_pop_length      (in_pop_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_head_byte      (out_head_byte),
    .out_head_valid     (out_head_valid),
    .out_buffered_count (out_buffered_count),
    .out_free_space     (out_free_space),
    .out_total_pushed   (out_total_pushed),
    .out_total_popped   (out_total_popped),
    .out_closed_flag    (out_closed_flag),
    .out_finished_flag  (out_finished_flag),
    .out_byte_accepted  (out_byte_accepted)
  );

  bsf_status_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .in_pop_length      (in_pop_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_head_byte      (out_head_byte),
    .out_head_valid     (out_head_valid),
    .out_buffered_count (out_buffered_count),
    .out_free_space     (out_free_space),
    .out_total_pushed   (out_total_pushed),
    .out_total_popped   (out_total_popped),
    .out_closed_flag    (out_closed_flag),
    .out_finished_flag  (out_finished_flag),
    .out_byte_accepted  (out_byte_accepted),
    .fail_count         (fail_count),
    .expected_left      (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_item(input logic [1:0] mode, input logic [BYTE_W-1:0] data,
                           input logic [FLD_W-1:0] len);
    int r;
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        burst_left = $urandom_range(20, 80);
      end else if (r >= 60 && r < 93) begin
        gap = $urandom_range(1, 3);
      end else if (r >= 93) begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_byte <= data;
    in_pop_length <= len;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_items(input int count, input int push_pct, input int pop_max,
                              input bit allow_close);
    int r;
    logic [1:0] mode;
    logic [FLD_W-1:0] len;
    logic [BYTE_W-1:0] data;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) mode = MODE_PUSH;
      else if (r < 96) mode = MODE_POP;
      else if (r < 98 || !allow_close) mode = MODE_IDLE;
      else mode = MODE_CLOSE;
      if ($urandom_range(0, 49) == 0) len = FLD_W'($urandom_range(0, 8191));
      else len = FLD_W'($urandom_range(0, pop_max));
      data = BYTE_W'($urandom_range(0, 255));
      send_item(mode, data, len);
    end
  endtask

  // drain: stop offering and wait for every outstanding status transfer
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [FLD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : consumer
    int r;
    int quiet;
    bit held_long;
    quiet = 0;
    held_long = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_trigger && !held_long) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (quiet > 0) begin
          quiet--;
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (r < 4) begin
          quiet = $urandom_range(20, 80);
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (r < 70) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (r < 96) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_mode <= MODE_PUSH;
    in_data_byte <= '0;
    in_pop_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: byte extremes, empty and oversized pops, unused mode
    send_item(MODE_PUSH, 8'h00, 13'h0000);
    send_item(MODE_PUSH, 8'hFF, 13'h1FFF);
    send_item(MODE_PUSH, 8'hA5, 13'h0000);
    send_item(MODE_POP, 8'h00, 13'h0000);
    send_item(MODE_POP, 8'hFF, 13'h0001);
    send_item(MODE_IDLE, 8'hFF, 13'h1FFF);
    send_item(MODE_POP, 8'h00, 13'h1FFF);
    send_item(MODE_POP, 8'h00, 13'h0001);
    send_item(MODE_PUSH, 8'h5A, 13'h0AAA);
    send_item(MODE_PUSH, 8'h3C, 13'h1555);
    send_item(MODE_POP, 8'hC3, 13'h0002);

    settle();
    write_capacity(13'd1);
    random_items(150, 55, 3, 1'b0);

    settle();
    write_capacity(13'd0);
    random_items(40, 70, 2, 1'b0);

    // above depth saturates; consumer holds off so the input backs up
    settle();
    write_capacity(13'h1FFF);
    hold_trigger <= 1'b1;
    random_items(300, 85, 4, 1'b0);

    // drop the limit under what is buffered
    settle();
    write_capacity(13'd3);
    random_items(150, 50, 2, 1'b0);

    settle();
    write_capacity(13'd2);
    random_items(150, 60, 2, 1'b0);

    repeat (5) begin
      settle();
      write_capacity(FLD_W'($urandom_range(1, 64)));
      random_items(100, 60, 6, 1'b0);
    end

    settle();
    write_capacity(13'd4096);
    random_items(200, 65, 8, 1'b0);

    // end of stream: close with data held, push after close, repeated close
    settle();
    send_item(MODE_PUSH, 8'h11, 13'h0000);
    send_item(MODE_PUSH, 8'hEE, 13'h0000);
    send_item(MODE_CLOSE, 8'h00, 13'h0000);
    send_item(MODE_PUSH, 8'h77, 13'h0000);
    send_item(MODE_CLOSE, 8'hFF, 13'h1FFF);
    send_item(MODE_POP, 8'h00, 13'h0001);
    send_item(MODE_IDLE, 8'h00, 13'h0000);
    send_item(MODE_POP, 8'h00, 13'h1FFF);
    send_item(MODE_POP, 8'h00, 13'h0000);
    send_item(MODE_PUSH, 8'h33, 13'h0000);
    send_item(MODE_CLOSE, 8'h00, 13'h0000);
    random_items(100, 40, 4, 1'b1);

    settle();
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
